@@ rtl/rgb_threshold_morph_open_unit_macros.svh @@
// Assertion macros for the threshold and opening unit.
// Used by the modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef RGB_THRESHOLD_MORPH_OPEN_UNIT_MACROS_SVH
`define RGB_THRESHOLD_MORPH_OPEN_UNIT_MACROS_SVH
`ifndef SYNTH
// Condition that holds at every clock edge outside reset
`define RTMO_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("rtmo check failed");
// Condition that must hold in the cycle after a trigger
`define RTMO_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rtmo check failed");
`else
`define RTMO_ASSERT(lbl, cond)
`define RTMO_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

@@ rtl/rtmo_pkg.sv @@
// Shared types and constants of the threshold and opening unit.
// No dependencies.
package rtmo_pkg;

  localparam int KERNEL_SIZE = 5;
  localparam int RAD         = KERNEL_SIZE / 2;
  localparam int MAX_HEIGHT  = 1024;
  localparam int ROW_W       = 11;   // holds 0..MAX_HEIGHT
  localparam int RING_W      = 4;    // 16-row ring in the line memories
  localparam int WORD_COLS   = 4;    // columns packed in one memory word
  localparam int WORD_BITS   = (1 << RING_W) * WORD_COLS;
  localparam int CFG_W       = 11;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WIDTH     = 2'd1;
  localparam logic [1:0] REG_HEIGHT    = 2'd2;

  localparam logic [7:0]       THR_RESET = 8'd128;
  localparam logic [ROW_W-1:0] H_RESET   = 11'd480;

  typedef struct packed {
    logic       req_type;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
  } rtmo_in_t;

  typedef struct packed {
    logic [7:0] clean_value;
    logic [9:0] out_row;
    logic [9:0] out_col;
    logic       frame_last;
  } rtmo_out_t;

  // Per-transaction decisions of the scheduler
  typedef struct packed {
    logic take;   // pixel written to the binary line memory
    logic ero;    // one erosion result computed
    logic emit;   // one output pixel produced
    logic last;   // emitted pixel closes the frame
  } rtmo_ctl_t;

endpackage

@@ rtl/rgb_threshold_morph_open_unit.sv @@
// Threshold plus 5x5 opening. Accepts one transaction per cycle while the output
// is not stalled; a result leaves through the write, erosion read, erosion write,
// dilation read and output register stages, one result per cycle sustained without stalls.
// Throughput is set by the one-write/two-read line memories, one access per cycle each.
// Synchronous active-low reset clears counters, configuration and valid bits;
// the line memories are not cleared (every window tap is rewritten in the frame).
module rgb_threshold_morph_open_unit import rtmo_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  rtmo_in_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rtmo_out_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic             adv, step, bin, ero_bit, dil_bit;
  rtmo_ctl_t        ctl, ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r;
  logic [ROW_W-1:0] in_row, er_row, o_row, h_eff;
  logic [CW-1:0]    in_col, er_col, o_col;
  logic [CW:0]      w_eff;
  logic             bin1_r, out_valid_r;
  logic [ROW_W-1:0] irow1_r, erow1_r, erow2_r, erow3_r;
  logic [CW-1:0]    icol1_r, ecol1_r, ecol2_r, ecol3_r;
  logic [ROW_W-1:0] orow1_r, orow2_r, orow3_r, orow4_r, orow5_r;
  logic [CW-1:0]    ocol1_r, ocol2_r, ocol3_r, ocol4_r, ocol5_r;
  logic [CW+9:0]    ocol_ext;
  rtmo_out_t        out_r;

  // The pipeline moves unless a result waits at a stalled output
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign step     = in_valid && adv;

  rtmo_sched #(.MAX_WIDTH(MAX_WIDTH)) u_sched (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .step     (step),
    .in_data  (in_data),
    .ctl      (ctl),
    .bin      (bin),
    .in_row   (in_row),
    .in_col   (in_col),
    .er_row   (er_row),
    .er_col   (er_col),
    .o_row    (o_row),
    .o_col    (o_col),
    .w_eff    (w_eff),
    .h_eff    (h_eff)
  );

  // Stage control valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
    end else if (adv) begin
      ctl1_r <= ctl;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r;
    end
  end

  // Stage positions
  always_ff @(posedge clk) begin
    if (adv) begin
      bin1_r  <= bin;
      irow1_r <= in_row;
      icol1_r <= in_col;
      erow1_r <= er_row;
      ecol1_r <= er_col;
      erow2_r <= erow1_r;
      ecol2_r <= ecol1_r;
      erow3_r <= erow2_r;
      ecol3_r <= ecol2_r;
      orow1_r <= o_row;
      ocol1_r <= o_col;
      orow2_r <= orow1_r;
      ocol2_r <= ocol1_r;
      orow3_r <= orow2_r;
      ocol3_r <= ocol2_r;
      orow4_r <= orow3_r;
      ocol4_r <= ocol3_r;
      orow5_r <= orow4_r;
      ocol5_r <= ocol4_r;
    end
  end

  // Binary line memory: pixel written in stage 1, erosion window read in stage 2
  rtmo_morph_stage #(.MAX_WIDTH(MAX_WIDTH), .ERODE(1'b1)) u_erode (
    .clk   (clk),
    .adv   (adv),
    .wr_en (ctl1_r.take),
    .wr_row(irow1_r),
    .wr_col(icol1_r),
    .wr_bit(bin1_r),
    .rd_row(erow2_r),
    .rd_col(ecol2_r),
    .w_eff (w_eff),
    .h_eff (h_eff),
    .res   (ero_bit)
  );

  // Eroded line memory: written in stage 3, dilation window read in stage 4
  rtmo_morph_stage #(.MAX_WIDTH(MAX_WIDTH), .ERODE(1'b0)) u_dilate (
    .clk   (clk),
    .adv   (adv),
    .wr_en (ctl3_r.ero),
    .wr_row(erow3_r),
    .wr_col(ecol3_r),
    .wr_bit(ero_bit),
    .rd_row(orow4_r),
    .rd_col(ocol4_r),
    .w_eff (w_eff),
    .h_eff (h_eff),
    .res   (dil_bit)
  );

  assign ocol_ext = {10'b0, ocol5_r};

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl5_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl5_r.emit) begin
      out_r.clean_value <= dil_bit ? 8'hFF : 8'h00;
      out_r.out_row     <= orow5_r[9:0];
      out_r.out_col     <= ocol_ext[9:0];
      out_r.frame_last  <= ctl5_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/rtmo_morph_stage.sv @@
// One morphology pass: 16-row ring line memory (4 columns per word, two read ports)
// and the 5x5 AND (erosion) or OR (dilation) over the in-frame window. Uses rtmo_pkg.
module rtmo_morph_stage import rtmo_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter bit ERODE     = 1'b1
) (
  input  logic                         clk,
  input  logic                         adv,
  input  logic                         wr_en,
  input  logic [ROW_W-1:0]             wr_row,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_col,
  input  logic                         wr_bit,
  input  logic [ROW_W-1:0]             rd_row,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_col,
  input  logic [$clog2(MAX_WIDTH):0]   w_eff,
  input  logic [ROW_W-1:0]             h_eff,
  output logic                         res
);

  localparam int CW    = $clog2(MAX_WIDTH);
  // column c sits at position c+4, so a window starting left of the frame stays in range
  localparam int DEPTH = (MAX_WIDTH + WORD_COLS - 1) / WORD_COLS + 2;
  localparam int AW    = $clog2(DEPTH);

  logic [WORD_BITS-1:0] mem_r [DEPTH];
  logic [WORD_BITS-1:0] lo_r, hi_r;
  logic [ROW_W-1:0]     row_q_r;
  logic [CW-1:0]        col_q_r;

  logic [AW-1:0] wa, ra0, ra1;
  logic [CW:0]   cp2;

  // Addresses: write word of the column, read the two words spanning columns c-2..c+2
  always_comb begin
    wa  = AW'(({1'b0, wr_col} >> 2) + (CW+1)'(1));
    cp2 = {1'b0, rd_col} + (CW+1)'(RAD);
    ra0 = AW'(cp2 >> 2);
    ra1 = ra0 + AW'(1);
  end

  // Bit write into the ring slot, registered two-word read
  always_ff @(posedge clk) begin
    if (adv && wr_en) begin
      mem_r[wa][{wr_row[RING_W-1:0], wr_col[1:0]}] <= wr_bit;
    end
    if (adv) begin
      lo_r    <= mem_r[ra0];
      hi_r    <= mem_r[ra1];
      row_q_r <= rd_row;
      col_q_r <= rd_col;
    end
  end

  // Window reduction over in-frame taps only
  always_comb begin
    logic [2*WORD_BITS-1:0] pair;
    logic [RING_W-1:0]      slot;
    logic [ROW_W:0]         rsum;
    logic [CW+1:0]          csum;
    logic [1:0]             base;
    logic [2:0]             kb;
    logic                   rok, cok, acc;
    pair = {hi_r, lo_r};
    base = col_q_r[1:0] + 2'(RAD);
    acc  = ERODE;
    for (int dr = 0; dr < KERNEL_SIZE; dr++) begin
      slot = row_q_r[RING_W-1:0] + RING_W'(dr) - RING_W'(RAD);
      rsum = {1'b0, row_q_r} + (ROW_W+1)'(dr);
      rok  = (rsum >= (ROW_W+1)'(RAD)) && (rsum < ({1'b0, h_eff} + (ROW_W+1)'(RAD)));
      for (int dc = 0; dc < KERNEL_SIZE; dc++) begin
        kb   = {1'b0, base} + 3'(dc);
        csum = {2'b0, col_q_r} + (CW+2)'(dc);
        cok  = (csum >= (CW+2)'(RAD)) && (csum < ({1'b0, w_eff} + (CW+2)'(RAD)));
        if (rok && cok) begin
          if (ERODE) begin
            acc = acc & pair[{kb[2], slot, kb[1:0]}];
          end else begin
            acc = acc | pair[{kb[2], slot, kb[1:0]}];
          end
        end
      end
    end
    res = acc;
  end

endmodule

@@ rtl/rtmo_sched.sv @@
// Configuration registers, frame position counters and per-transaction scheduling
// of pixel write, erosion and output. Uses rtmo_pkg and the assertion macros.
`include "rgb_threshold_morph_open_unit_macros.svh"
module rtmo_sched import rtmo_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [1:0]                   cfg_index,
  input  logic [CFG_W-1:0]             cfg_data,
  input  logic                         step,
  input  rtmo_in_t                     in_data,
  output rtmo_ctl_t                    ctl,
  output logic                         bin,
  output logic [ROW_W-1:0]             in_row,
  output logic [$clog2(MAX_WIDTH)-1:0] in_col,
  output logic [ROW_W-1:0]             er_row,
  output logic [$clog2(MAX_WIDTH)-1:0] er_col,
  output logic [ROW_W-1:0]             o_row,
  output logic [$clog2(MAX_WIDTH)-1:0] o_col,
  output logic [$clog2(MAX_WIDTH):0]   w_eff,
  output logic [ROW_W-1:0]             h_eff
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam logic [CW:0] W_RESET = (640 > MAX_WIDTH) ? (CW+1)'(MAX_WIDTH) : (CW+1)'(640);

  logic [7:0]       thr_r;
  logic [CW:0]      w_r;
  logic [ROW_W-1:0] h_r;
  logic [ROW_W-1:0] in_row_r, in_row_nxt, er_row_r, er_row_nxt, o_row_r, o_row_nxt;
  logic [CW-1:0]    in_col_r, in_col_nxt, er_col_r, er_col_nxt, o_col_r, o_col_nxt;
  logic [CW:0]      w_clamp;
  logic [ROW_W-1:0] h_clamp;
  logic [9:0]       sum, lim;
  logic [ROW_W-1:0] e_lr, o_lr, h_m1;
  logic [CW:0]      e_lc, o_lc, w_m1;
  logic             restart;

  // Clamp written frame sizes to the supported range
  always_comb begin
    if (cfg_data < CFG_W'(KERNEL_SIZE)) begin
      w_clamp = (CW+1)'(KERNEL_SIZE);
    end else if (32'(cfg_data) > MAX_WIDTH) begin
      w_clamp = (CW+1)'(MAX_WIDTH);
    end else begin
      w_clamp = (CW+1)'(cfg_data);
    end
    if (cfg_data < CFG_W'(KERNEL_SIZE)) begin
      h_clamp = ROW_W'(KERNEL_SIZE);
    end else if (32'(cfg_data) > MAX_HEIGHT) begin
      h_clamp = ROW_W'(MAX_HEIGHT);
    end else begin
      h_clamp = ROW_W'(cfg_data);
    end
  end

  // Threshold: bin is set when floor(sum/3) <= T, that is sum <= 3T+2
  always_comb begin
    sum = {2'b0, in_data.chan0} + {2'b0, in_data.chan1} + {2'b0, in_data.chan2};
    lim = {2'b0, thr_r} + {1'b0, thr_r, 1'b0} + 10'd2;
    bin = (sum <= lim);
  end

  // Step decisions; each later stage sees the positions updated by the earlier one
  always_comb begin
    h_m1 = h_r - ROW_W'(1);
    w_m1 = w_r - (CW+1)'(1);

    ctl.take   = step && !in_data.req_type && (in_row_r < h_r);
    in_row_nxt = in_row_r;
    in_col_nxt = in_col_r;
    if (ctl.take) begin
      if ({1'b0, in_col_r} == w_m1) begin
        in_row_nxt = in_row_r + ROW_W'(1);
        in_col_nxt = '0;
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
    end

    // last input the erosion window needs
    e_lr = ((er_row_r + ROW_W'(RAD)) > h_m1) ? h_m1 : (er_row_r + ROW_W'(RAD));
    e_lc = (({1'b0, er_col_r} + (CW+1)'(RAD)) > w_m1) ? w_m1 :
           ({1'b0, er_col_r} + (CW+1)'(RAD));
    ctl.ero = step && (er_row_r < h_r) &&
              ((e_lr < in_row_nxt) || ((e_lr == in_row_nxt) && (e_lc < {1'b0, in_col_nxt})));
    er_row_nxt = er_row_r;
    er_col_nxt = er_col_r;
    if (ctl.ero) begin
      if ({1'b0, er_col_r} == w_m1) begin
        er_row_nxt = er_row_r + ROW_W'(1);
        er_col_nxt = '0;
      end else begin
        er_col_nxt = er_col_r + CW'(1);
      end
    end

    // last eroded pixel the dilation window needs
    o_lr = ((o_row_r + ROW_W'(RAD)) > h_m1) ? h_m1 : (o_row_r + ROW_W'(RAD));
    o_lc = (({1'b0, o_col_r} + (CW+1)'(RAD)) > w_m1) ? w_m1 :
           ({1'b0, o_col_r} + (CW+1)'(RAD));
    ctl.emit = step && (o_row_r < h_r) &&
               ((o_lr < er_row_nxt) || ((o_lr == er_row_nxt) && (o_lc < {1'b0, er_col_nxt})));
    ctl.last = ctl.emit && (o_row_r == h_m1) && ({1'b0, o_col_r} == w_m1);
    o_row_nxt = o_row_r;
    o_col_nxt = o_col_r;
    if (ctl.emit) begin
      if ({1'b0, o_col_r} == w_m1) begin
        o_row_nxt = o_row_r + ROW_W'(1);
        o_col_nxt = '0;
      end else begin
        o_col_nxt = o_col_r + CW'(1);
      end
    end

    restart = cfg_wr_en && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
      w_r   <= W_RESET;
      h_r   <= H_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_THRESHOLD: thr_r <= cfg_data[7:0];
        REG_WIDTH:     w_r   <= w_clamp;
        REG_HEIGHT:    h_r   <= h_clamp;
        default:       ;
      endcase
    end
  end

  // Position counters; frame end or a size write restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n || restart || ctl.last) begin
      in_row_r <= '0;
      in_col_r <= '0;
      er_row_r <= '0;
      er_col_r <= '0;
      o_row_r  <= '0;
      o_col_r  <= '0;
    end else begin
      in_row_r <= in_row_nxt;
      in_col_r <= in_col_nxt;
      er_row_r <= er_row_nxt;
      er_col_r <= er_col_nxt;
      o_row_r  <= o_row_nxt;
      o_col_r  <= o_col_nxt;
    end
  end

  assign in_row = in_row_r;
  assign in_col = in_col_r;
  assign er_row = er_row_r;
  assign er_col = er_col_r;
  assign o_row  = o_row_r;
  assign o_col  = o_col_r;
  assign w_eff  = w_r;
  assign h_eff  = h_r;

  // erosion never runs ahead of the input, output never ahead of erosion
  `RTMO_ASSERT(a_ero_behind_in, (er_row_r < in_row_r) || ((er_row_r == in_row_r) && (er_col_r <= in_col_r)))
  `RTMO_ASSERT(a_out_behind_ero, (o_row_r < er_row_r) || ((o_row_r == er_row_r) && (o_col_r <= er_col_r)))
  `RTMO_ASSERT(a_cols_in_frame, ({1'b0, in_col_r} < w_r) && ({1'b0, er_col_r} < w_r) && ({1'b0, o_col_r} < w_r))
  `RTMO_ASSERT_NEXT(a_size_restart, restart, (in_row_r == '0) && (er_row_r == '0) && (o_row_r == '0) && (o_col_r == '0))

endmodule
